@@ sv/isfp_pkg.sv @@
// Shared types and constants for the IMU serial frame parser.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package isfp_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_FIRST  = 8'h50;
  localparam logic [7:0] TYPE_LAST   = 8'h58;
  localparam int unsigned FRAME_LEN  = 11;
  localparam logic [3:0] LAST_POS    = 4'(FRAME_LEN - 1);
  localparam logic [3:0] FIRST_PAYLOAD_POS = 4'd2;
  localparam logic [3:0] LAST_PAYLOAD_POS  = 4'd9;
  localparam int unsigned PAYLOAD_BYTES    = 8;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [3:0]                        kind;
    logic [PAYLOAD_BYTES-1:0][7:0]     payload;
  } frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

@@ sv/isfp_front.sv @@
// Front part: collects received bytes into frames and classifies them.
// Depends on isfp_pkg; hands finished frames of a known type to the queue.
`default_nettype none

module isfp_front
  import isfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output frame_t          frame,
  output logic            frame_push
);

  logic [3:0]                    count;
  logic [3:0]                    count_next;
  logic [7:0]                    type_byte;
  logic [PAYLOAD_BYTES-1:0][7:0] payload;
  logic [2:0]                    slot;
  logic                          type_known;
  logic [3:0]                    kind;

  assign slot       = 3'(count - FIRST_PAYLOAD_POS);
  assign type_known = (type_byte >= TYPE_FIRST) && (type_byte <= TYPE_LAST);
  assign kind       = 4'(type_byte - TYPE_FIRST);

  always_comb begin
    count_next = count;
    if (accept) begin
      if (count == 4'd0) begin
        count_next = (rx_byte == HEADER_BYTE) ? 4'd1 : 4'd0;
      end else if (count >= LAST_POS) begin
        count_next = 4'd0;
      end else begin
        count_next = count + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 4'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && count == 4'd1) begin
      type_byte <= rx_byte;
    end
    if (accept && count >= FIRST_PAYLOAD_POS && count <= LAST_PAYLOAD_POS) begin
      payload[slot] <= rx_byte;
    end
  end

  assign frame_push    = accept && (count == LAST_POS) && type_known;
  assign frame.kind    = kind;
  assign frame.payload = payload;

endmodule

`default_nettype wire

@@ sv/isfp_queue.sv @@
// Short frame queue between the front and back parts.
// Depends on isfp_pkg for the frame and status types.
`default_nettype none

module isfp_queue
  import isfp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_en,
  input  wire frame_t wr_frame,
  input  wire logic   rd_en,
  output frame_t      rd_frame,
  output q_status_t   status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  frame_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_frame;
    end
  end

  assign rd_frame     = slots[rd_ptr];
  assign status.empty = (fill == '0);
  assign status.full  = (fill == FULL_CNT);

endmodule

`default_nettype wire

@@ sv/isfp_back.sv @@
// Back part: takes frames from the queue and presents the decoded fields.
// Depends on isfp_pkg; holds one result in its output register.
`default_nettype none

module isfp_back
  import isfp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire frame_t    head,
  input  wire q_status_t q_status,
  output logic           take,
  input  wire logic      pop,
  output logic           empty,
  output logic [3:0]     packet_kind,
  output logic [15:0]    word_zero,
  output logic [15:0]    word_one,
  output logic [15:0]    word_two,
  output logic [15:0]    word_three,
  output logic [31:0]    long_first,
  output logic [31:0]    long_second
);

  logic   held;
  frame_t result;

  assign take = !q_status.empty && (!held || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (pop) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= head;
    end
  end

  assign empty       = !held;
  assign packet_kind = result.kind;
  assign word_zero   = {result.payload[1], result.payload[0]};
  assign word_one    = {result.payload[3], result.payload[2]};
  assign word_two    = {result.payload[5], result.payload[4]};
  assign word_three  = {result.payload[7], result.payload[6]};
  assign long_first  = {result.payload[0], result.payload[1],
                        result.payload[2], result.payload[3]};
  assign long_second = {result.payload[4], result.payload[5],
                        result.payload[6], result.payload[7]};

endmodule

`default_nettype wire

@@ sv/imu_serial_frame_parser.sv @@
// IMU serial frame parser: takes one received byte per cycle unless full.
// A finished frame passes through the frame queue and then the output register.
// Bytes are taken one per cycle while full is low; full is the queue's full
// flag, and with QUEUE_DEPTH above one the output register then holds a result.
// Synchronous reset empties the queue and output and restarts frame collection.
`default_nettype none

module imu_serial_frame_parser
  import isfp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte,
  input  wire logic       pop,
  output logic            empty,
  output logic [3:0]      packet_kind,
  output logic [15:0]     word_zero,
  output logic [15:0]     word_one,
  output logic [15:0]     word_two,
  output logic [15:0]     word_three,
  output logic [31:0]     long_first,
  output logic [31:0]     long_second
);

  frame_t    new_frame;
  frame_t    head;
  logic      frame_push;
  logic      take;
  logic      accept;
  q_status_t q_status;

  assign full   = q_status.full;
  assign accept = push && !full;

  isfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (rx_byte),
    .frame      (new_frame),
    .frame_push (frame_push)
  );

  isfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (frame_push),
    .wr_frame (new_frame),
    .rd_en    (take),
    .rd_frame (head),
    .status   (q_status)
  );

  isfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .take        (take),
    .pop         (pop),
    .empty       (empty),
    .packet_kind (packet_kind),
    .word_zero   (word_zero),
    .word_one    (word_one),
    .word_two    (word_two),
    .word_three  (word_three),
    .long_first  (long_first),
    .long_second (long_second)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    frame_push |-> !q_status.full)
    else $error("Frame pushed into a full queue.");

  a_status_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("Queue reports full and empty together.");

  a_result_arrives: assert property (@(posedge clk) disable iff (rst)
    (frame_push && q_status.empty && empty) |=> ##1 !empty)
    else $error("Completed frame did not reach the output.");

  a_take_has_data: assert property (@(posedge clk) disable iff (rst)
    take |-> !q_status.empty)
    else $error("Output loaded from an empty queue.");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the IMU serial frame parser: bytes go in through the
// push/full port, and frames come out through the pop/empty port, checked field by field.
// Depends on isfp_pkg and imu_serial_frame_parser.
`default_nettype none

module testbench
  import isfp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef enum int unsigned {
    POP_ALWAYS,
    POP_MOSTLY,
    POP_RARELY,
    POP_STALLED
  } pop_mode_t;

  typedef struct {
    logic [3:0]  kind;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;
    logic [31:0] long0;
    logic [31:0] long1;
  } frame_result_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  rx_byte;
  logic        pop;
  logic        empty;
  logic [3:0]  packet_kind;
  logic [15:0] word_zero;
  logic [15:0] word_one;
  logic [15:0] word_two;
  logic [15:0] word_three;
  logic [31:0] long_first;
  logic [31:0] long_second;

  logic [7:0]    frame_store [0:FRAME_LEN-1];
  int unsigned   frame_fill;
  frame_result_t pending_frames [$];
  int unsigned   error_count;
  int unsigned   bytes_counted;
  int unsigned   burst_left;
  int unsigned   cycle_count;
  bit            sender_gaps;

  imu_serial_frame_parser u_top (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .rx_byte     (rx_byte),
    .pop         (pop),
    .empty       (empty),
    .packet_kind (packet_kind),
    .word_zero   (word_zero),
    .word_one    (word_one),
    .word_two    (word_two),
    .word_three  (word_three),
    .long_first  (long_first),
    .long_second (long_second)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[imu_serial_frame_parser] ERROR");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  // Mirrors the frame collector; called once for every accepted byte.
  task automatic track_byte(input logic [7:0] value, output bit dropped);
    frame_result_t res;
    if (frame_fill >= FRAME_LEN) begin
      frame_fill = 0;
    end
    frame_store[frame_fill] = value;
    frame_fill++;
    dropped = (frame_store[0] != HEADER_BYTE);
    if (dropped) begin
      frame_fill = 0;
    end else if (frame_fill == FRAME_LEN) begin
      frame_fill = 0;
      if (frame_store[1] >= TYPE_FIRST && frame_store[1] <= TYPE_LAST) begin
        res.kind  = 4'(frame_store[1] - TYPE_FIRST);
        res.word0 = {frame_store[3], frame_store[2]};
        res.word1 = {frame_store[5], frame_store[4]};
        res.word2 = {frame_store[7], frame_store[6]};
        res.word3 = {frame_store[9], frame_store[8]};
        res.long0 = {frame_store[2], frame_store[3], frame_store[4], frame_store[5]};
        res.long1 = {frame_store[6], frame_store[7], frame_store[8], frame_store[9]};
        pending_frames.push_back(res);
      end
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && pop && !empty) begin
      if (pending_frames.size() == 0) begin
        report_error("result delivered with no frame outstanding");
      end else begin
        want = pending_frames.pop_front();
        check_field("packet_kind", 32'(packet_kind), 32'(want.kind));
        check_field("word_zero", 32'(word_zero), 32'(want.word0));
        check_field("word_one", 32'(word_one), 32'(want.word1));
        check_field("word_two", 32'(word_two), 32'(want.word2));
        check_field("word_three", 32'(word_three), 32'(want.word3));
        check_field("long_first", long_first, want.long0);
        check_field("long_second", long_second, want.long1);
      end
    end
  end

  // The receiver switches between pop modes, holding each for a random span.
  initial begin
    pop_mode_t   mode;
    int unsigned span;
    pop = 1'b0;
    forever begin
      mode = pop_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          POP_ALWAYS: pop <= 1'b1;
          POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
          POP_RARELY: pop <= ($urandom_range(0, 7) == 0);
          default:    pop <= ($urandom_range(0, 29) == 0);
        endcase
      end
    end
  end

  // Entered and left at a falling edge; push stays high for the next request.
  task automatic send_byte(input logic [7:0] value);
    bit dropped;
    if (sender_gaps && burst_left == 0) begin
      push <= 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(9, 40)) @(negedge clk);
      end else begin
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    push    <= 1'b1;
    rx_byte <= value;
    do @(posedge clk); while (full);
    track_byte(value, dropped);
    if (!dropped) begin
      bytes_counted++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    burst_left = 0;
    while (pending_frames.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return HEADER_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_type();
    if ($urandom_range(0, 99) < 85) begin
      return TYPE_FIRST + 8'($urandom_range(0, 8));
    end
    return pick_byte();
  endfunction

  task automatic send_frame(input logic [7:0] kind_byte, input int unsigned tail_len);
    send_byte(HEADER_BYTE);
    send_byte(kind_byte);
    repeat (tail_len) send_byte(pick_byte());
  endtask

  task automatic send_fixed_frame(input logic [7:0] kind_byte, input logic [7:0] fill,
                                  input logic [7:0] checksum);
    send_byte(HEADER_BYTE);
    send_byte(kind_byte);
    repeat (PAYLOAD_BYTES) send_byte(fill);
    send_byte(checksum);
  endtask

  task automatic test_bad_header();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_field_extremes();
    send_fixed_frame(TYPE_FIRST, 8'hFF, 8'h00);
  endtask

  task automatic test_unknown_type();
    send_fixed_frame(TYPE_LAST + 8'd1, 8'h00, 8'hFF);
  endtask

  // Mostly whole frames, with some cut short and some stray bytes between them.
  task automatic test_random_traffic(input int unsigned quota, input bit with_gaps);
    int unsigned start;
    int unsigned choice;
    start = bytes_counted;
    sender_gaps = with_gaps;
    while (bytes_counted - start < quota) begin
      choice = $urandom_range(0, 99);
      if (choice < 80) begin
        send_frame(pick_type(), FRAME_LEN - 2);
      end else if (choice < 90) begin
        send_frame(pick_type(), $urandom_range(0, FRAME_LEN - 3));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(pick_byte());
      end
    end
  endtask

  task automatic test_pause_until_drained();
    sender_gaps = 1'b0;
    send_frame(pick_type(), FRAME_LEN - 2);
    send_frame(pick_type(), FRAME_LEN - 2);
    wait_drained();
  endtask

  initial begin
    rst         = 1'b1;
    push        = 1'b0;
    rx_byte     = 8'h00;
    frame_fill  = 0;
    error_count = 0;
    bytes_counted = 0;
    burst_left  = 0;
    cycle_count = 0;
    sender_gaps = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_bad_header();
    test_field_extremes();
    test_unknown_type();
    test_random_traffic(600, 1'b1);
    test_pause_until_drained();
    test_random_traffic(400, 1'b0);
    test_random_traffic(550, 1'b1);

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[imu_serial_frame_parser] OK");
    end else begin
      $display("[imu_serial_frame_parser] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/isfp_pkg.sv
sv/isfp_front.sv
sv/isfp_queue.sv
sv/isfp_back.sv
sv/imu_serial_frame_parser.sv
bench/testbench.sv
